### rtl/gmp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the grid maximum path sum block
// no dependencies

package gmp_pkg;

    localparam int COST_W          = 16;
    localparam int SUM_W           = 22;
    localparam int CFG_W           = 6;
    localparam int CFG_IDX_W       = 1;
    localparam int OUT_DATA_W      = 24;
    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLUMNS = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    // result of the cell stage, handed to the traceback unit
    typedef struct packed {
        logic             vld;
        logic             run_end;
        logic             from_above;
        logic [SUM_W-1:0] total;
    } t_cell_res;

    typedef enum logic [5:0] {
        TS_IDLE    = 6'b000001,
        TS_ADDR    = 6'b000010,
        TS_WALK    = 6'b000100,
        TS_TOTAL   = 6'b001000,
        TS_POP_RD  = 6'b010000,
        TS_POP_OUT = 6'b100000
    } t_trace_state;

endpackage

### rtl/gmp_cell_unit.sv
`timescale 1ns / 1ps
// cell stage: row sum memory, left sum and add/compare for one cell per cycle
// depends on gmp_pkg

module gmp_cell_unit #(
    parameter int MAX_ROWS    = gmp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = gmp_pkg::DEF_MAX_COLUMNS,
    parameter int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_acc,
    input  logic [gmp_pkg::COST_W-1:0] i_cost,
    input  logic [ROW_W-1:0]          i_row,
    input  logic [COL_W-1:0]          i_col,
    input  logic                      i_run_end,
    output gmp_pkg::t_cell_res        o_res,
    output logic [ROW_W-1:0]          o_row,
    output logic [COL_W-1:0]          o_col
);

    logic [gmp_pkg::SUM_W-1:0]  row_mem [MAX_COLUMNS];
    logic [gmp_pkg::SUM_W-1:0]  r_above_q;
    logic [gmp_pkg::SUM_W-1:0]  r_left;
    logic [gmp_pkg::COST_W-1:0] r_cost;
    logic [ROW_W-1:0]           r_row;
    logic [COL_W-1:0]           r_col;
    logic                       r_vld;
    logic                       r_run_end;
    logic                       r_fwd;

    logic [gmp_pkg::SUM_W-1:0] above;
    logic [gmp_pkg::SUM_W-1:0] base;
    logic [gmp_pkg::SUM_W-1:0] total;
    logic                      row_first;
    logic                      col_first;
    logic                      from_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_run_end <= 1'b0;
            r_fwd     <= 1'b0;
            r_left    <= '0;
        end else begin
            r_vld     <= i_acc;
            r_run_end <= i_acc && i_run_end;
            if (i_acc) begin
                // previous cell writes the same column this edge
                r_fwd <= r_vld && (r_col == i_col);
            end
            if (r_vld) begin
                r_left <= total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_above_q <= row_mem[i_col];
            r_cost    <= i_cost;
            r_row     <= i_row;
            r_col     <= i_col;
        end
        if (r_vld) begin
            row_mem[r_col] <= total;
        end
    end

    always_comb begin
        row_first  = (r_row == '0);
        col_first  = (r_col == '0);
        above      = r_fwd ? r_left : r_above_q;
        from_above = !row_first && (col_first || ($signed(above) > $signed(r_left)));
        if (row_first && col_first) begin
            base = '0;
        end else if (from_above) begin
            base = above;
        end else begin
            base = r_left;
        end
        total = base + {{(gmp_pkg::SUM_W - gmp_pkg::COST_W){r_cost[gmp_pkg::COST_W-1]}},
                        r_cost};
    end

    assign o_res.vld        = r_vld;
    assign o_res.run_end    = r_run_end;
    assign o_res.from_above = from_above;
    assign o_res.total      = total;
    assign o_row            = r_row;
    assign o_col            = r_col;

endmodule

### rtl/gmp_trace_unit.sv
`timescale 1ns / 1ps
// direction bit memory, traceback walk, move stack and output register
// depends on gmp_pkg

module gmp_trace_unit #(
    parameter int MAX_ROWS    = gmp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = gmp_pkg::DEF_MAX_COLUMNS,
    parameter int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gmp_pkg::t_cell_res            i_res,
    input  logic [ROW_W-1:0]              i_row,
    input  logic [COL_W-1:0]              i_col,
    input  logic [ROW_W-1:0]              i_rows_m1,
    input  logic [COL_W-1:0]              i_cols_m1,
    output logic                          o_idle,
    output logic                          o_out_vld,
    input  logic                          i_out_rdy,
    output logic                          o_out_user,
    output logic                          o_out_last,
    output logic [gmp_pkg::OUT_DATA_W-1:0] o_out_data
);

    localparam int DIR_D  = 2 ** (ROW_W + COL_W);
    localparam int STK_D  = MAX_ROWS + MAX_COLUMNS;
    localparam int STK_AW = $clog2(STK_D);
    localparam int PTR_W  = $clog2(STK_D + 1);

    logic dir_mem [DIR_D];
    logic stk_mem [STK_D];

    gmp_pkg::t_trace_state r_state, n_state;
    logic [ROW_W-1:0]           r_tr, n_tr;
    logic [COL_W-1:0]           r_tc, n_tc;
    logic [PTR_W-1:0]           r_ptr, n_ptr;
    logic [PTR_W-1:0]           ptr_dec;
    logic                       r_dir_q;
    logic                       r_st_q;
    logic [gmp_pkg::SUM_W-1:0]  r_total;
    logic                       r_out_vld;
    logic                       r_out_user;
    logic                       r_out_last;
    logic [gmp_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                           out_free;
    logic                           out_load;
    logic                           out_user;
    logic                           out_last;
    logic [gmp_pkg::OUT_DATA_W-1:0] out_data;
    logic                           st_we;
    logic                           st_re;
    logic                           down;

    assign out_free = !r_out_vld || i_out_rdy;
    assign ptr_dec  = r_ptr - 1'b1;

    always_comb begin
        n_state  = r_state;
        n_tr     = r_tr;
        n_tc     = r_tc;
        n_ptr    = r_ptr;
        st_we    = 1'b0;
        st_re    = 1'b0;
        down     = 1'b0;
        out_load = 1'b0;
        out_user = 1'b0;
        out_last = 1'b0;
        out_data = '0;
        unique case (r_state)
            gmp_pkg::TS_IDLE: begin
                if (i_res.vld && i_res.run_end) begin
                    n_state = gmp_pkg::TS_ADDR;
                end
            end
            gmp_pkg::TS_ADDR: begin
                n_tr    = i_rows_m1;
                n_tc    = i_cols_m1;
                n_ptr   = '0;
                n_state = gmp_pkg::TS_WALK;
            end
            gmp_pkg::TS_WALK: begin
                if (r_tr == '0 && r_tc == '0) begin
                    n_state = gmp_pkg::TS_TOTAL;
                end else begin
                    if (r_tr == '0) begin
                        down = 1'b0;
                    end else if (r_tc == '0) begin
                        down = 1'b1;
                    end else begin
                        down = r_dir_q;
                    end
                    st_we = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    if (down) begin
                        n_tr = r_tr - 1'b1;
                    end else begin
                        n_tc = r_tc - 1'b1;
                    end
                end
            end
            gmp_pkg::TS_TOTAL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_user = 1'b1;
                    out_last = (r_ptr == '0);
                    out_data = {{(gmp_pkg::OUT_DATA_W - gmp_pkg::SUM_W){1'b0}}, r_total};
                    n_state  = (r_ptr == '0) ? gmp_pkg::TS_IDLE : gmp_pkg::TS_POP_RD;
                end
            end
            gmp_pkg::TS_POP_RD: begin
                st_re   = 1'b1;
                n_ptr   = ptr_dec;
                n_state = gmp_pkg::TS_POP_OUT;
            end
            gmp_pkg::TS_POP_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = (r_ptr == '0);
                    out_data = {{(gmp_pkg::OUT_DATA_W - gmp_pkg::SUM_W - 1){1'b0}}, r_st_q,
                                {gmp_pkg::SUM_W{1'b0}}};
                    n_state  = (r_ptr == '0) ? gmp_pkg::TS_IDLE : gmp_pkg::TS_POP_RD;
                end
            end
            default: begin
                n_state = gmp_pkg::TS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gmp_pkg::TS_IDLE;
            r_ptr     <= '0;
            r_tr      <= '0;
            r_tc      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_tr    <= n_tr;
            r_tc    <= n_tc;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.vld) begin
            dir_mem[{i_row, i_col}] <= i_res.from_above;
        end
        r_dir_q <= dir_mem[{n_tr, n_tc}];
        if (i_res.vld && i_res.run_end) begin
            r_total <= i_res.total;
        end
        if (st_we) begin
            stk_mem[r_ptr[STK_AW-1:0]] <= down;
        end
        if (st_re) begin
            r_st_q <= stk_mem[ptr_dec[STK_AW-1:0]];
        end
        if (out_load) begin
            r_out_user <= out_user;
            r_out_last <= out_last;
            r_out_data <= out_data;
        end
    end

    assign o_idle     = (r_state == gmp_pkg::TS_IDLE);
    assign o_out_vld  = r_out_vld;
    assign o_out_user = r_out_user;
    assign o_out_last = r_out_last;
    assign o_out_data = r_out_data;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < PTR_W'(STK_D))
        else $error("move stack pointer out of range");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.vld |-> (r_state == gmp_pkg::TS_IDLE))
        else $error("cell result while traceback busy");

    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmp_pkg::TS_WALK) |-> (r_tr <= i_rows_m1 && r_tc <= i_cols_m1))
        else $error("traceback walked outside the grid");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmp_pkg::TS_POP_RD) |-> (r_ptr != '0))
        else $error("pop from empty move stack");

endmodule

### rtl/grid_max_path_sum_traceback.sv
`timescale 1ns / 1ps
// Maximum path sum over a grid, moving right or down, with traceback. Cells stream in
// row-major order at one item per clock while the traceback is idle; each cell does one
// add and compare against the row sum memory. After the last cell the block walks the
// direction bit memory from the bottom-right corner, one move per cycle (moves = rows +
// columns - 2), then sends the total and pops the moves in forward order, each pop a
// stack read and then an output load that waits for a free output; no cells are taken
// meanwhile. Ties go to the left neighbor. A size of zero counts as one, a size above
// the maximum saturates, and any register write restarts the run at the top-left cell.
// depends on gmp_pkg, gmp_cell_unit, gmp_trace_unit

module grid_max_path_sum_traceback #(
    parameter int MAX_ROWS    = gmp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = gmp_pkg::DEF_MAX_COLUMNS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [gmp_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gmp_pkg::COST_W-1:0]       s_axis_tdata,   // cell_cost
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gmp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // path_total, move_down, pad
    output logic                             m_axis_tuser,   // is_total
    output logic                             m_axis_tlast
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [gmp_pkg::CFG_W:0] MAX_ROWS_C = (gmp_pkg::CFG_W + 1)'(MAX_ROWS);
    localparam logic [gmp_pkg::CFG_W:0] MAX_COLS_C = (gmp_pkg::CFG_W + 1)'(MAX_COLUMNS);

    logic [gmp_pkg::CFG_W-1:0] r_row_count;
    logic [gmp_pkg::CFG_W-1:0] r_column_count;
    logic [ROW_W-1:0]          r_row;
    logic [COL_W-1:0]          r_col;
    logic [ROW_W-1:0]          rows_m1;
    logic [COL_W-1:0]          cols_m1;
    logic                      acc;
    logic                      last_col;
    logic                      run_end;
    logic                      trace_idle;

    gmp_pkg::t_cell_res cell_res;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;

    always_comb begin
        if (r_row_count == '0) begin
            rows_m1 = '0;
        end else if ({1'b0, r_row_count} > MAX_ROWS_C) begin
            rows_m1 = ROW_W'(MAX_ROWS - 1);
        end else begin
            rows_m1 = ROW_W'(r_row_count - 1'b1);
        end
        if (r_column_count == '0) begin
            cols_m1 = '0;
        end else if ({1'b0, r_column_count} > MAX_COLS_C) begin
            cols_m1 = COL_W'(MAX_COLUMNS - 1);
        end else begin
            cols_m1 = COL_W'(r_column_count - 1'b1);
        end
    end

    assign s_axis_tready = trace_idle && !(cell_res.vld && cell_res.run_end);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign last_col      = (r_col == cols_m1);
    assign run_end       = last_col && (r_row == rows_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= gmp_pkg::CFG_W'(1);
            r_column_count <= gmp_pkg::CFG_W'(1);
            r_row          <= '0;
            r_col          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                gmp_pkg::REG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                gmp_pkg::REG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                default: ;
            endcase
            r_row <= '0;
            r_col <= '0;
        end else if (acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= run_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    gmp_cell_unit #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROW_W       (ROW_W),
        .COL_W       (COL_W)
    ) u_cell (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_cost    (s_axis_tdata),
        .i_row     (r_row),
        .i_col     (r_col),
        .i_run_end (run_end),
        .o_res     (cell_res),
        .o_row     (cell_row),
        .o_col     (cell_col)
    );

    gmp_trace_unit #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROW_W       (ROW_W),
        .COL_W       (COL_W)
    ) u_trace (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (cell_res),
        .i_row      (cell_row),
        .i_col      (cell_col),
        .i_rows_m1  (rows_m1),
        .i_cols_m1  (cols_m1),
        .o_idle     (trace_idle),
        .o_out_vld  (m_axis_tvalid),
        .i_out_rdy  (m_axis_tready),
        .o_out_user (m_axis_tuser),
        .o_out_last (m_axis_tlast),
        .o_out_data (m_axis_tdata)
    );

endmodule
